### sv/rebq_pkg.sv
// rebq_pkg: shared types and constants of the rotary encoder button qualifier
// holds register codes, register reset values, widths and the config struct
// no dependencies
package rebq_pkg;

   // default counter width of the quadrature counter
   localparam int COUNTER_BITS_DEF = 16;

   // configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = 3;

   // register indexes, byte address is four times the index
   localparam logic [REG_IDX_W-1:0] REG_DETENT_DIVIDER = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_HOLD_TIME      = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_DBL_TAP        = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE       = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_SPEED_WINDOW   = 3'd4;

   // accepted divider codes
   localparam logic [2:0] DIV_ONE  = 3'd1;
   localparam logic [2:0] DIV_TWO  = 3'd2;
   localparam logic [2:0] DIV_FOUR = 3'd4;

   // register reset values
   localparam logic [2:0]  DIVIDER_RST      = 3'd4;
   localparam logic [15:0] HOLD_TIME_RST    = 16'd1000;
   localparam logic [15:0] DBL_TAP_RST      = 16'd400;
   localparam logic [15:0] DEBOUNCE_RST     = 16'd20;
   localparam logic [15:0] SPEED_WINDOW_RST = 16'd250;

   // speed estimate arithmetic
   localparam int          TIME_W     = 32;
   localparam int          RATE_W     = 16;
   localparam int          SCALE_W    = 10;
   localparam logic [SCALE_W-1:0] RATE_SCALE = 10'd1000;
   localparam int          PROD_W     = TIME_W + SCALE_W;

   // configuration seen by the datapath
   typedef struct packed {
      logic [2:0]  detent_divider;
      logic [15:0] hold_ms;
      logic [15:0] dbl_tap_ms;
      logic [15:0] debounce_ms;
      logic [15:0] speed_window_ms;
      logic        divider_clear;
   } cfg_type;

endpackage

### sv/rebq_csr.sv
// rebq_csr: configuration registers behind the apb-style port
// depends on rebq_pkg for register codes, reset values and cfg_type
module rebq_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [rebq_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [rebq_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [rebq_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready,
   output rebq_pkg::cfg_type                  cfg
);

   logic [2:0]                     divider_ff;
   logic [15:0]                    hold_time_ff;
   logic [15:0]                    dbl_tap_ff;
   logic [15:0]                    debounce_ff;
   logic [15:0]                    speed_window_ff;
   logic                           wr_en;
   logic                           div_ok;
   logic [rebq_pkg::REG_IDX_W-1:0] idx;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign idx    = paddr[rebq_pkg::CSR_ADDR_W-1:2];
   assign div_ok = (pwdata[2:0] == rebq_pkg::DIV_ONE) || (pwdata[2:0] == rebq_pkg::DIV_TWO)
                || (pwdata[2:0] == rebq_pkg::DIV_FOUR);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         divider_ff      <= rebq_pkg::DIVIDER_RST;
         hold_time_ff    <= rebq_pkg::HOLD_TIME_RST;
         dbl_tap_ff      <= rebq_pkg::DBL_TAP_RST;
         debounce_ff     <= rebq_pkg::DEBOUNCE_RST;
         speed_window_ff <= rebq_pkg::SPEED_WINDOW_RST;
      end else begin
         if (wr_en) begin
            unique case (idx)
               rebq_pkg::REG_DETENT_DIVIDER: begin
                  if (div_ok) begin
                     divider_ff <= pwdata[2:0];
                  end
               end
               rebq_pkg::REG_HOLD_TIME:    hold_time_ff    <= pwdata[15:0];
               rebq_pkg::REG_DBL_TAP:      dbl_tap_ff      <= pwdata[15:0];
               rebq_pkg::REG_DEBOUNCE:     debounce_ff     <= pwdata[15:0];
               rebq_pkg::REG_SPEED_WINDOW: speed_window_ff <= pwdata[15:0];
               default: ;
            endcase
         end
      end
   end

   // read mux
   always_comb begin
      unique case (idx)
         rebq_pkg::REG_DETENT_DIVIDER: prdata = rebq_pkg::CSR_DATA_W'(divider_ff);
         rebq_pkg::REG_HOLD_TIME:      prdata = rebq_pkg::CSR_DATA_W'(hold_time_ff);
         rebq_pkg::REG_DBL_TAP:        prdata = rebq_pkg::CSR_DATA_W'(dbl_tap_ff);
         rebq_pkg::REG_DEBOUNCE:       prdata = rebq_pkg::CSR_DATA_W'(debounce_ff);
         rebq_pkg::REG_SPEED_WINDOW:   prdata = rebq_pkg::CSR_DATA_W'(speed_window_ff);
         default:                      prdata = '0;
      endcase
   end

   assign cfg.detent_divider  = divider_ff;
   assign cfg.hold_ms         = hold_time_ff;
   assign cfg.dbl_tap_ms      = dbl_tap_ff;
   assign cfg.debounce_ms     = debounce_ff;
   assign cfg.speed_window_ms = speed_window_ff;
   // pulse at the edge that takes an accepted divider write
   assign cfg.divider_clear   = wr_en && (idx == rebq_pkg::REG_DETENT_DIVIDER) && div_ok;

endmodule

### sv/rebq_rate_div.sv
// rebq_rate_div: iterative unit for the detents per second estimate
// computes min(65535, sum * 1000 / elapsed), one quotient bit per cycle
// depends on rebq_pkg for widths and the scale constant
module rebq_rate_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [rebq_pkg::TIME_W-1:0]    sum,
   input  logic [rebq_pkg::TIME_W-1:0]    elapsed,
   output logic                           done,
   output logic [rebq_pkg::RATE_W-1:0]    rate
);

   localparam int TW = rebq_pkg::TIME_W;
   localparam int QW = rebq_pkg::RATE_W;
   localparam int PW = rebq_pkg::PROD_W;
   localparam int CW = $clog2(QW);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_MUL  = 2'd1;
   localparam logic [1:0] PH_CHK  = 2'd2;
   localparam logic [1:0] PH_RUN  = 2'd3;

   logic [1:0]    phase_ff;
   logic [CW-1:0] cnt_ff;
   logic          done_ff;
   logic [TW-1:0] num_ff;
   logic [TW-1:0] den_ff;
   logic [PW-1:0] prod_ff;
   logic [TW-1:0] prem_ff;
   logic [QW-1:0] quo_ff;
   logic [QW-1:0] rate_ff;

   logic [TW:0]      trial;
   logic [TW:0]      trial_sub;
   logic             trial_fits;
   logic [PW-QW-1:0] prod_high;
   logic             over;

   // one restoring division step
   assign trial      = {prem_ff, quo_ff[QW-1]};
   assign trial_fits = trial >= {1'b0, den_ff};
   assign trial_sub  = trial - {1'b0, den_ff};

   // quotient reaches 2^16 exactly when the upper product bits reach the divisor
   assign prod_high = prod_ff[PW-1:QW];
   assign over      = TW'(prod_high) >= den_ff;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (phase_ff)
            PH_IDLE: if (start) phase_ff <= PH_MUL;
            PH_MUL:  phase_ff <= PH_CHK;
            PH_CHK: begin
               cnt_ff <= '0;
               if (over) begin
                  phase_ff <= PH_IDLE;
                  done_ff  <= 1'b1;
               end else begin
                  phase_ff <= PH_RUN;
               end
            end
            PH_RUN: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CW'(QW - 1)) begin
                  phase_ff <= PH_IDLE;
                  done_ff  <= 1'b1;
               end
            end
            default: phase_ff <= PH_IDLE;
         endcase
      end
   end

   // operands, product, partial remainder and quotient
   always_ff @(posedge clock) begin
      if (phase_ff == PH_IDLE && start) begin
         num_ff <= sum;
         den_ff <= elapsed;
      end
      if (phase_ff == PH_MUL) prod_ff <= num_ff * rebq_pkg::RATE_SCALE;
      if (phase_ff == PH_CHK) begin
         prem_ff <= TW'(prod_high);
         quo_ff  <= prod_ff[QW-1:0];
         if (over) rate_ff <= '1;
      end
      if (phase_ff == PH_RUN) begin
         prem_ff <= trial_fits ? trial_sub[TW-1:0] : trial[TW-1:0];
         quo_ff  <= {quo_ff[QW-2:0], trial_fits};
         if (cnt_ff == CW'(QW - 1)) rate_ff <= {quo_ff[QW-2:0], trial_fits};
      end
   end

   assign done = done_ff;
   assign rate = rate_ff;

endmodule

### sv/rotary_encoder_button_qualifier_unit.sv
// rotary_encoder_button_qualifier_unit: detent counter, speed estimate and button qualifier
// depends on rebq_pkg, rebq_csr and rebq_rate_div
//
//   channel  ports                          direction  word
//   req      req_valid / req_ready          in         counter value, button level, time
//   rsp      rsp_valid / rsp_ready          out        detents, speed, button events, totals
//   csr      psel penable pwrite paddr ...  in/out     five registers at 4*index
//
// a poll word passes the rotation and done states, and the speed state if its window closes
// (the rate divider multiplies once, then unless saturated works one quotient bit per cycle)
// reset is synchronous and clears the control and persistent state; no clearing pass
// a new word is taken while the last result still waits in the output register
// the finished result holds until that register is free

module rotary_encoder_button_qualifier_unit #(
   parameter int COUNTER_BITS = rebq_pkg::COUNTER_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [15:0]                      req_count_value,
   input  logic                             req_button_raw,
   input  logic [31:0]                      req_now_ms,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [15:0]               rsp_detent_steps,
   output logic [15:0]                      rsp_steps_per_second,
   output logic                             rsp_tap,
   output logic                             rsp_dbl_tap,
   output logic                             rsp_hold,
   output logic [31:0]                      rsp_event_count,
   output logic signed [31:0]               rsp_step_total,
   output logic                             rsp_activity_seen,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [rebq_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [rebq_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [rebq_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);

   localparam int CB     = COUNTER_BITS;
   localparam int EXT_W  = CB + 16;
   localparam int SUM_W  = CB + 1;
   localparam int WIDE_W = SUM_W + 16;
   localparam logic signed [WIDE_W-1:0] SAT_HI = WIDE_W'(32767);
   localparam logic signed [WIDE_W-1:0] SAT_LO = WIDE_W'(-32768);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ROT   = 2'd1;
   localparam logic [1:0] ST_SPEED = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   rebq_pkg::cfg_type cfg;

   logic [1:0]        state_ff;
   logic [CB-1:0]     cnt_ff;
   logic              raw_ff;
   logic [31:0]       now_ff;

   logic [CB-1:0]     prev_ff;
   logic signed [2:0] rem_ff;
   logic              bstate_ff;
   logic [31:0]       bct_ff;
   logic              lr_ff;
   logic [31:0]       lst_ff;
   logic              seen_ff;
   logic [31:0]       wstart_ff;
   logic [31:0]       wsum_ff;
   logic [15:0]       speed_ff;
   logic [31:0]       evc_ff;
   logic [31:0]       total_ff;

   logic signed [15:0] steps_ff;
   logic              sp_ff;
   logic              dc_ff;
   logic              lp_ff;

   logic              rsp_valid_ff;
   logic signed [15:0] rsp_steps_ff;
   logic [15:0]       rsp_speed_ff;
   logic              rsp_sp_ff;
   logic              rsp_dc_ff;
   logic              rsp_lp_ff;
   logic [31:0]       rsp_evc_ff;
   logic [31:0]       rsp_total_ff;
   logic              rsp_seen_ff;

   logic [EXT_W-1:0]        cnt_ext;
   logic [CB-1:0]           diff;
   logic signed [SUM_W-1:0] sum;
   logic signed [SUM_W-1:0] bias;
   logic signed [SUM_W-1:0] det;
   logic signed [SUM_W-1:0] rem_full;
   logic signed [WIDE_W-1:0] det_wide;
   logic [1:0]              shift;
   logic signed [15:0]      steps;
   logic [15:0]             mag;
   logic [32:0]             acc;
   logic [31:0]             wsum_new;
   logic [31:0]             win;
   logic [31:0]             elapsed;
   logic                    win_close;
   logic                    btn_change;
   logic                    bstate_new;
   logic [31:0]             bct_new;
   logic                    lr_new;
   logic                    sp;
   logic                    dc;
   logic                    lp;
   logic                    div_done;
   logic [15:0]             div_rate;
   logic                    out_free;

   rebq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rebq_rate_div u_rate_div (
      .clock   (clock),
      .reset   (reset),
      .start   (state_ff == ST_ROT && win_close),
      .sum     (wsum_new),
      .elapsed (elapsed),
      .done    (div_done),
      .rate    (div_rate)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cnt_ext   = EXT_W'(req_count_value);

   // rotation: wrapped difference, remainder and truncating division by 1, 2 or 4
   always_comb begin
      shift    = cfg.detent_divider[2] ? 2'd2 : (cfg.detent_divider[1] ? 2'd1 : 2'd0);
      diff     = cnt_ff - prev_ff;
      sum      = SUM_W'($signed(diff)) + SUM_W'(rem_ff);
      bias     = sum[SUM_W-1] ? $signed(SUM_W'(cfg.detent_divider - 3'd1)) : '0;
      det      = (sum + bias) >>> shift;
      rem_full = sum - (det <<< shift);
      det_wide = WIDE_W'(det);
      if (det_wide > SAT_HI) steps = 16'sh7fff;
      else if (det_wide < SAT_LO) steps = 16'sh8000;
      else steps = det_wide[15:0];
   end

   // speed window bookkeeping
   always_comb begin
      mag       = steps[15] ? 16'(-steps) : 16'(steps);
      acc       = {1'b0, wsum_ff} + 33'(mag);
      wsum_new  = acc[32] ? '1 : acc[31:0];
      win       = (cfg.speed_window_ms == '0) ? 32'd1 : 32'(cfg.speed_window_ms);
      elapsed   = now_ff - wstart_ff;
      win_close = elapsed >= win;
   end

   // button debounce, short press, double click and long press
   always_comb begin
      btn_change = (raw_ff != bstate_ff) && ((now_ff - bct_ff) >= 32'(cfg.debounce_ms));
      bstate_new = btn_change ? raw_ff : bstate_ff;
      bct_new    = btn_change ? now_ff : bct_ff;
      lr_new     = lr_ff;
      sp         = 1'b0;
      dc         = 1'b0;
      if (btn_change) begin
         if (raw_ff) begin
            lr_new = 1'b0;
         end else if (!lr_ff) begin
            sp = 1'b1;
            dc = (now_ff - lst_ff) <= 32'(cfg.dbl_tap_ms);
         end
      end
      lp = bstate_new && !lr_new && ((now_ff - bct_new) >= 32'(cfg.hold_ms));
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE:  if (req_valid) state_ff <= ST_ROT;
            ST_ROT:   state_ff <= win_close ? ST_SPEED : ST_DONE;
            ST_SPEED: if (div_done) state_ff <= ST_DONE;
            ST_DONE:  if (out_free) state_ff <= ST_IDLE;
            default:  state_ff <= ST_IDLE;
         endcase
      end
   end

   // input word capture
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cnt_ff <= cnt_ext[CB-1:0];
         raw_ff <= req_button_raw;
         now_ff <= req_now_ms;
      end
   end

   // persistent state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= '0;
         rem_ff    <= '0;
         bstate_ff <= 1'b0;
         bct_ff    <= '0;
         lr_ff     <= 1'b0;
         lst_ff    <= '0;
         seen_ff   <= 1'b0;
         wstart_ff <= '0;
         wsum_ff   <= '0;
         speed_ff  <= '0;
         evc_ff    <= '0;
         total_ff  <= '0;
      end else begin
         // a divider write drops the remainder
         if (cfg.divider_clear) rem_ff <= '0;
         else if (state_ff == ST_ROT) rem_ff <= rem_full[2:0];
         if (state_ff == ST_ROT) begin
            prev_ff   <= cnt_ff;
            bstate_ff <= bstate_new;
            bct_ff    <= bct_new;
            lr_ff     <= lr_new | lp;
            if (sp) lst_ff <= now_ff;
            if (steps != '0 || btn_change) seen_ff <= 1'b1;
            if (win_close) begin
               wsum_ff   <= '0;
               wstart_ff <= now_ff;
            end else begin
               wsum_ff <= wsum_new;
            end
            total_ff <= total_ff + 32'(steps);
            if (steps != '0 || sp || dc || lp) evc_ff <= evc_ff + 32'd1;
         end
         if (state_ff == ST_SPEED && div_done) speed_ff <= div_rate;
      end
   end

   // per-word event flags
   always_ff @(posedge clock) begin
      if (state_ff == ST_ROT) begin
         steps_ff <= steps;
         sp_ff    <= sp;
         dc_ff    <= dc;
         lp_ff    <= lp;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_free) begin
         rsp_steps_ff <= steps_ff;
         rsp_speed_ff <= speed_ff;
         rsp_sp_ff    <= sp_ff;
         rsp_dc_ff    <= dc_ff;
         rsp_lp_ff    <= lp_ff;
         rsp_evc_ff   <= evc_ff;
         rsp_total_ff <= total_ff;
         rsp_seen_ff  <= seen_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_detent_steps     = rsp_steps_ff;
   assign rsp_steps_per_second = rsp_speed_ff;
   assign rsp_tap              = rsp_sp_ff;
   assign rsp_dbl_tap          = rsp_dc_ff;
   assign rsp_hold             = rsp_lp_ff;
   assign rsp_event_count      = rsp_evc_ff;
   assign rsp_step_total       = $signed(rsp_total_ff);
   assign rsp_activity_seen    = rsp_seen_ff;

endmodule

### sv/rebq_checker.sv
// rebq_checker: port-level assertions for the rotary encoder button qualifier
// watches handshake and result ports only; bound to rotary_encoder_button_qualifier_unit below
module rebq_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic                             rsp_tap,
   input  logic                             rsp_dbl_tap,
   input  logic                             rsp_hold,
   input  logic [31:0]                      rsp_event_count,
   input  logic signed [31:0]               rsp_step_total,
   input  logic                             rsp_activity_seen
);

   // no result is shown right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // one word at a time: taking a word drops ready for the next cycle
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready stayed high after a word was taken");

   // a double click is a short press, and a release never carries a long press
   a_button_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((!rsp_dbl_tap || rsp_tap) && !(rsp_tap && rsp_hold)))
      else $error("inconsistent button flags");

   // the activity flag never falls between back-to-back results
   a_activity_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_activity_seen) |=> (!rsp_valid || rsp_activity_seen))
      else $error("activity flag cleared");

   // a stalled result holds its totals
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_event_count)
                                     && $stable(rsp_step_total)))
      else $error("stalled result changed");

endmodule

bind rotary_encoder_button_qualifier_unit rebq_checker u_rebq_checker (.*);

### bench/tb_rotary_encoder_button_qualifier_unit.sv
// testbench for the rotary encoder detent counter and button qualifier
// drives poll words and register writes, predicts every result word and checks it
// depends on rebq_pkg and rotary_encoder_button_qualifier_unit
`timescale 1ns / 100ps

module tb_rotary_encoder_button_qualifier_unit;

   localparam int QUIET_LIMIT = 4000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PHASES = 8;
   localparam int POLLS_PER_PHASE = 138;

   // divider values the block must ignore
   localparam logic [2:0] DIV_ZERO  = 3'd0;
   localparam logic [2:0] DIV_THREE = 3'd3;
   localparam logic [2:0] DIV_SEVEN = 3'd7;

   typedef struct packed {
      logic signed [15:0] detent_steps;
      logic [15:0]        steps_per_second;
      logic               tap;
      logic               dbl_tap;
      logic               hold;
      logic [31:0]        event_count;
      logic signed [31:0] step_total;
      logic               activity_seen;
   } poll_result_type;

   typedef enum logic {ROW_POLL, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type    kind;
      logic [2:0]      reg_idx;
      logic [31:0]     wdata;
      logic [15:0]     count;
      logic            button;
      logic [31:0]     stamp;
      bit              typed;
      poll_result_type want;
   } stim_row_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [15:0] req_count_value = '0;
   logic req_button_raw = 1'b0;
   logic [31:0] req_now_ms = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_detent_steps;
   logic [15:0] rsp_steps_per_second;
   logic rsp_tap;
   logic rsp_dbl_tap;
   logic rsp_hold;
   logic [31:0] rsp_event_count;
   logic signed [31:0] rsp_step_total;
   logic rsp_activity_seen;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [rebq_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [rebq_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [rebq_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;

   rotary_encoder_button_qualifier_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_count_value(req_count_value), .req_button_raw(req_button_raw),
      .req_now_ms(req_now_ms),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_detent_steps(rsp_detent_steps), .rsp_steps_per_second(rsp_steps_per_second),
      .rsp_tap(rsp_tap), .rsp_dbl_tap(rsp_dbl_tap),
      .rsp_hold(rsp_hold), .rsp_event_count(rsp_event_count),
      .rsp_step_total(rsp_step_total), .rsp_activity_seen(rsp_activity_seen),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // register copies
   logic [2:0]  div_cfg;
   logic [15:0] long_cfg, dbl_cfg, deb_cfg, win_cfg;

   // encoder and button state as the block should hold it
   logic [15:0] last_count;
   int          rem_steps;
   logic        btn_level;
   logic [31:0] btn_time;
   logic        long_done;
   logic [31:0] short_time;
   logic        active_flag;
   logic [31:0] win_start, win_sum;
   logic [15:0] rate_est;
   logic [31:0] evt_cnt, det_sum;

   poll_result_type pending_poll_results[$];
   stim_row_type    directed_rows[$];
   int              mismatch_count = 0;
   int              quiet_cycles = 0;
   bit              burst_mode = 1'b0;
   bit              hold_request = 1'b0;
   poll_result_type observed, oldest;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // next result word for one poll word, advances the state copy
   function automatic poll_result_type predict_poll_result(logic [15:0] cnt, logic b,
                                                           logic [31:0] t);
      poll_result_type res;
      longint delta, total_s, whole, dv;
      longint unsigned mag, acc, rate;
      logic [15:0] diff;
      logic [31:0] elapsed, win, held, since_short;
      int steps;
      logic sp, dc, lp;
      steps = 0;
      sp = 1'b0;
      dc = 1'b0;
      lp = 1'b0;
      dv = div_cfg;

      // rotation, wrapped difference then truncating division
      diff = cnt - last_count;
      delta = diff;
      if (diff[15]) delta = delta - 65536;
      last_count = cnt;
      if (delta != 0) begin
         total_s = rem_steps + delta;
         whole = total_s / dv;
         if (whole != 0) begin
            rem_steps = int'(total_s - whole * dv);
            if (whole > 32767) whole = 32767;
            if (whole < -32768) whole = -32768;
            steps = int'(whole);
            active_flag = 1'b1;
         end else begin
            rem_steps = int'(total_s);
         end
      end

      // speed estimate over the window
      mag = (steps < 0) ? -steps : steps;
      acc = {32'd0, win_sum} + mag;
      win = (win_cfg == 16'd0) ? 32'd1 : {16'd0, win_cfg};
      elapsed = t - win_start;
      win_sum = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
      if (elapsed >= win) begin
         rate = ({32'd0, win_sum} * 64'd1000) / {32'd0, elapsed};
         rate_est = (rate > 64'd65535) ? 16'hFFFF : rate[15:0];
         win_sum = '0;
         win_start = t;
      end
      det_sum = det_sum + steps;

      // button debounce and press qualification
      held = t - btn_time;
      if (b != btn_level && held >= deb_cfg) begin
         btn_level = b;
         btn_time = t;
         active_flag = 1'b1;
         if (b) begin
            long_done = 1'b0;
         end else if (!long_done) begin
            sp = 1'b1;
            since_short = t - short_time;
            if (since_short <= dbl_cfg) dc = 1'b1;
            short_time = t;
         end
      end
      held = t - btn_time;
      if (btn_level && !long_done && held >= long_cfg) begin
         long_done = 1'b1;
         lp = 1'b1;
      end
      if (steps != 0 || sp || dc || lp) evt_cnt = evt_cnt + 1;

      res.detent_steps = 16'(steps);
      res.steps_per_second = rate_est;
      res.tap = sp;
      res.dbl_tap = dc;
      res.hold = lp;
      res.event_count = evt_cnt;
      res.step_total = det_sum;
      res.activity_seen = active_flag;
      return res;
   endfunction

   function automatic logic [31:0] reg_value(logic [2:0] idx);
      case (idx)
         rebq_pkg::REG_DETENT_DIVIDER: return {29'd0, div_cfg};
         rebq_pkg::REG_HOLD_TIME:      return {16'd0, long_cfg};
         rebq_pkg::REG_DBL_TAP:        return {16'd0, dbl_cfg};
         rebq_pkg::REG_DEBOUNCE:       return {16'd0, deb_cfg};
         rebq_pkg::REG_SPEED_WINDOW:   return {16'd0, win_cfg};
         default:                      return '0;
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      if (burst_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void add_poll(logic [15:0] c, logic b, logic [31:0] t,
                                    bit typed = 1'b0, poll_result_type want = '0);
      stim_row_type row;
      row.kind = ROW_POLL;
      row.reg_idx = '0;
      row.wdata = '0;
      row.count = c;
      row.button = b;
      row.stamp = t;
      row.typed = typed;
      row.want = want;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_write(logic [2:0] idx, logic [31:0] val);
      stim_row_type row;
      row.kind = ROW_WRITE;
      row.reg_idx = idx;
      row.wdata = val;
      row.count = '0;
      row.button = 1'b0;
      row.stamp = '0;
      row.typed = 1'b0;
      row.want = '0;
      directed_rows.push_back(row);
   endfunction

   // offer one poll word, then log its predicted result once taken
   task automatic send_poll(logic [15:0] cnt, logic b, logic [31:0] t,
                            bit typed, poll_result_type want);
      int gap;
      poll_result_type res;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_count_value <= cnt;
      req_button_raw <= b;
      req_now_ms <= t;
      @(posedge clock);
      while (!(req_valid && req_ready)) @(posedge clock);
      res = predict_poll_result(cnt, b, t);
      pending_poll_results.push_back(typed ? want : res);
   endtask

   // stop offering and let every outstanding result drain
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_poll_results.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         rebq_pkg::REG_DETENT_DIVIDER:
            if (val[2:0] == rebq_pkg::DIV_ONE || val[2:0] == rebq_pkg::DIV_TWO
                || val[2:0] == rebq_pkg::DIV_FOUR) begin
               div_cfg = val[2:0];
               rem_steps = 0;
            end
         rebq_pkg::REG_HOLD_TIME:    long_cfg = val[15:0];
         rebq_pkg::REG_DBL_TAP:      dbl_cfg = val[15:0];
         rebq_pkg::REG_DEBOUNCE:     deb_cfg = val[15:0];
         rebq_pkg::REG_SPEED_WINDOW: win_cfg = val[15:0];
         default: ;
      endcase
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // read back every register against the copies
   task automatic check_regs();
      logic [31:0] want;
      logic [2:0]  idx;
      for (int k = rebq_pkg::REG_DETENT_DIVIDER; k <= rebq_pkg::REG_SPEED_WINDOW; k++) begin
         idx = k[2:0];
         want = reg_value(idx);
         @(negedge clock);
         psel <= 1'b1;
         penable <= 1'b0;
         pwrite <= 1'b0;
         paddr <= {idx, 2'b00};
         @(negedge clock);
         penable <= 1'b1;
         @(posedge clock);
         while (!pready) @(posedge clock);
         if (prdata !== want) begin
            if (mismatch_count < 10)
               $display("register %0d read %h, expected %h", idx, prdata, want);
            mismatch_count++;
         end
         @(negedge clock);
         psel <= 1'b0;
         penable <= 1'b0;
      end
   endtask

   // result side, random stalls plus one long hold-off
   initial begin : result_sink
      int stall;
      forever begin
         stall = pick_gap();
         if (hold_request) begin
            hold_request = 1'b0;
            stall = HOLD_OFF_CYCLES;
         end
         if (stall > 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
      end
   end

   // compare each taken result word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         observed = {rsp_detent_steps, rsp_steps_per_second, rsp_tap,
                     rsp_dbl_tap, rsp_hold, rsp_event_count,
                     rsp_step_total, rsp_activity_seen};
         if (pending_poll_results.size() == 0) begin
            if (mismatch_count < 10)
               $display("result word with nothing pending: steps=%0d events=%0d",
                        observed.detent_steps, observed.event_count);
            mismatch_count++;
         end else begin
            oldest = pending_poll_results.pop_front();
            if (observed !== oldest) begin
               if (mismatch_count < 10)
                  $display({"result mismatch: expected steps=%0d sps=%0d sp=%0b dc=%0b",
                            " lp=%0b events=%0d total=%0d active=%0b; got steps=%0d",
                            " sps=%0d sp=%0b dc=%0b lp=%0b events=%0d total=%0d active=%0b"},
                           oldest.detent_steps, oldest.steps_per_second,
                           oldest.tap, oldest.dbl_tap, oldest.hold,
                           oldest.event_count, oldest.step_total, oldest.activity_seen,
                           observed.detent_steps, observed.steps_per_second,
                           observed.tap, observed.dbl_tap,
                           observed.hold, observed.event_count,
                           observed.step_total, observed.activity_seen);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on cycles with no transfer anywhere
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : stimulus
      int r;
      logic [2:0]  dv, bad_div;
      logic [15:0] lp_v, dc_v, db_v, sw_v, cnt_t;
      logic [31:0] now_t, plan_start, plan_len;
      logic        plan_level, b;

      // register and state copies at reset
      div_cfg = rebq_pkg::DIVIDER_RST;
      long_cfg = rebq_pkg::HOLD_TIME_RST;
      dbl_cfg = rebq_pkg::DBL_TAP_RST;
      deb_cfg = rebq_pkg::DEBOUNCE_RST;
      win_cfg = rebq_pkg::SPEED_WINDOW_RST;
      last_count = '0;
      rem_steps = 0;
      btn_level = 1'b0;
      btn_time = '0;
      long_done = 1'b0;
      short_time = '0;
      active_flag = 1'b0;
      win_start = '0;
      win_sum = '0;
      rate_est = '0;
      evt_cnt = '0;
      det_sum = '0;

      // directed words: fresh state, wraps, truncation, presses
      add_poll(16'h0000, 1'b0, 32'd0, 1'b1, poll_result_type'{16'sd0, 16'd0, 1'b0, 1'b0,
               1'b0, 32'd0, 32'sd0, 1'b0});
      add_poll(16'h0004, 1'b0, 32'd10, 1'b1, poll_result_type'{16'sd1, 16'd0, 1'b0, 1'b0,
               1'b0, 32'd1, 32'sd1, 1'b1});
      add_poll(16'hFFFC, 1'b0, 32'd20, 1'b1, poll_result_type'{-16'sd2, 16'd0, 1'b0, 1'b0,
               1'b0, 32'd2, -32'sd1, 1'b1});
      add_poll(16'hFFFD, 1'b0, 32'd30);
      // negative sum below one detent truncates to zero
      add_poll(16'hFFFB, 1'b0, 32'd40);
      // largest forward and backward counter jumps
      add_poll(16'h7FFA, 1'b0, 32'd60);
      add_poll(16'hFFFA, 1'b1, 32'd70);
      // bounce inside debounce, then first short press doubles against time zero
      add_poll(16'hFFFA, 1'b0, 32'd80);
      add_poll(16'hFFFA, 1'b0, 32'd150);
      add_poll(16'hFFFA, 1'b1, 32'd300);
      add_poll(16'hFFFA, 1'b0, 32'd320);
      // long press while held, no short press on release
      add_poll(16'hFFFA, 1'b1, 32'd400);
      add_poll(16'hFFFA, 1'b1, 32'd1400);
      add_poll(16'hFFFA, 1'b0, 32'd1500);
      // bad divider writes are dropped
      add_write(rebq_pkg::REG_DETENT_DIVIDER, {29'd0, DIV_THREE});
      add_write(rebq_pkg::REG_DETENT_DIVIDER, {29'd0, DIV_ZERO});
      add_write(rebq_pkg::REG_DETENT_DIVIDER, {29'd0, DIV_SEVEN});
      add_write(rebq_pkg::REG_DETENT_DIVIDER, {29'd0, rebq_pkg::DIV_ONE});
      add_write(rebq_pkg::REG_HOLD_TIME, 32'd0);
      add_write(rebq_pkg::REG_SPEED_WINDOW, 32'd0);
      add_write(rebq_pkg::REG_DEBOUNCE, 32'd0);
      add_write(rebq_pkg::REG_DBL_TAP, 32'd65535);
      // zero long press time, zero window, time wrap, saturated speed
      add_poll(16'hFFFB, 1'b1, 32'hFFFF_FFF0);
      add_poll(16'h7FFA, 1'b0, 32'd5);
      add_poll(16'h7FFA, 1'b0, 32'd5);
      add_write(rebq_pkg::REG_HOLD_TIME, 32'd65535);
      add_write(rebq_pkg::REG_DEBOUNCE, 32'd65535);
      add_write(rebq_pkg::REG_SPEED_WINDOW, 32'd65535);
      add_write(rebq_pkg::REG_DBL_TAP, 32'd0);
      add_write(rebq_pkg::REG_DETENT_DIVIDER, {29'd0, rebq_pkg::DIV_TWO});
      // longest debounce
      add_poll(16'h0000, 1'b1, 32'd100);
      add_poll(16'h8000, 1'b1, 32'd70000);
      add_poll(16'h8000, 1'b0, 32'd70010);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[n]) begin
         if (directed_rows[n].kind == ROW_WRITE) begin
            wait_for_results();
            csr_write(directed_rows[n].reg_idx, directed_rows[n].wdata);
         end else begin
            send_poll(directed_rows[n].count, directed_rows[n].button,
                      directed_rows[n].stamp, directed_rows[n].typed,
                      directed_rows[n].want);
         end
      end
      wait_for_results();
      check_regs();

      // random phases, each under its own register setting
      cnt_t = 16'h8000;
      now_t = 32'd70010;
      plan_level = 1'b0;
      plan_start = now_t;
      plan_len = 32'd100;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               dv = rebq_pkg::DIV_FOUR;
               lp_v = rebq_pkg::HOLD_TIME_RST;
               dc_v = rebq_pkg::DBL_TAP_RST;
               db_v = rebq_pkg::DEBOUNCE_RST;
               sw_v = rebq_pkg::SPEED_WINDOW_RST;
            end
            1: begin
               dv = rebq_pkg::DIV_ONE;
               lp_v = 16'd1;
               dc_v = 16'd1;
               db_v = 16'd0;
               sw_v = 16'd1;
            end
            2: begin
               dv = rebq_pkg::DIV_TWO;
               lp_v = 16'hFFFF;
               dc_v = 16'hFFFF;
               db_v = 16'hFFFF;
               sw_v = 16'hFFFF;
            end
            default: begin
               r = $urandom_range(0, 2);
               dv = (r == 0) ? rebq_pkg::DIV_ONE : (r == 1) ? rebq_pkg::DIV_TWO
                                                            : rebq_pkg::DIV_FOUR;
               lp_v = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(40, 1500));
               dc_v = 16'($urandom_range(30, 700));
               db_v = 16'($urandom_range(0, 40));
               sw_v = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 600));
            end
         endcase
         wait_for_results();
         r = $urandom_range(0, 2);
         bad_div = (r == 0) ? DIV_ZERO : (r == 1) ? DIV_THREE : DIV_SEVEN;
         csr_write(rebq_pkg::REG_DETENT_DIVIDER, {29'($urandom), dv});
         if ($urandom_range(0, 1) == 1)
            csr_write(rebq_pkg::REG_DETENT_DIVIDER, {29'($urandom), bad_div});
         csr_write(rebq_pkg::REG_HOLD_TIME, {16'($urandom), lp_v});
         csr_write(rebq_pkg::REG_DBL_TAP, {16'($urandom), dc_v});
         csr_write(rebq_pkg::REG_DEBOUNCE, {16'($urandom), db_v});
         csr_write(rebq_pkg::REG_SPEED_WINDOW, {16'($urandom), sw_v});
         check_regs();
         if (phase == 3) hold_request = 1'b1;

         for (int i = 0; i < POLLS_PER_PHASE; i++) begin
            if (i % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);

            // time mostly creeps forward, sometimes jumps or wraps
            r = $urandom_range(0, 99);
            if (r < 2) now_t = $urandom;
            else if (r < 3) now_t = 32'hFFFF_FFFF - 32'($urandom_range(0, 300));
            else if (r < 6) now_t = now_t + 32'($urandom_range(60000, 70000));
            else if (r < 15) now_t = now_t + 32'($urandom_range(100, 1500));
            else now_t = now_t + 32'($urandom_range(0, 30));

            // counter mostly turns a little either way
            r = $urandom_range(0, 99);
            if (r < 5) cnt_t = 16'($urandom);
            else if (r >= 40) cnt_t = cnt_t + 16'($urandom_range(0, 24)) - 16'd12;

            // button follows a press plan, with some contact bounce
            if (now_t - plan_start >= plan_len) begin
               plan_level = ~plan_level;
               plan_start = now_t;
               r = $urandom_range(0, 99);
               if (plan_level)
                  plan_len = (r < 50) ? 32'($urandom_range(20, 300)) :
                             (r < 80) ? 32'(lp_v) + 32'($urandom_range(0, 300)) :
                                        32'($urandom_range(300, 1200));
               else
                  plan_len = (r < 60) ? 32'($urandom_range(10, 500)) :
                                        32'($urandom_range(500, 2000));
            end
            b = plan_level;
            if ($urandom_range(0, 99) < 8) b = ~b;
            send_poll(cnt_t, b, now_t, 1'b0, '0);
         end
      end

      wait_for_results();
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && pending_poll_results.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
